/* rtl/pdg_pkg.sv */
`timescale 1ns / 1ps

package pdg_pkg;

    localparam int unsigned RATE_W  = 18;
    localparam int unsigned GAIN_W  = 15;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 18;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_SWAP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIVISOR  = 3'd4;

    // Reset values
    localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 18'd44100;
    localparam logic [RATE_W-1:0] TARGET_RATE_RST = 18'd22050;
    localparam logic              STEREO_RST      = 1'b1;
    localparam logic              BYTE_SWAP_RST   = 1'b0;
    localparam logic [GAIN_W-1:0] GAIN_RST        = 15'd1;

    typedef struct packed {
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
        logic              block_end;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] sample;
        logic                     block_end_res;
    } out_item_t;

endpackage

/* rtl/pcm_decimate_downmix_gain.sv */
`timescale 1ns / 1ps

// PCM sample-drop decimator with stereo downmix and gain. Each input beat is
// one frame; a phase accumulator adds min(target_rate, source_rate) and keeps
// the frame only when the sum reaches source_rate, so a dropped frame gives
// no output beat (and its block_end mark is lost). A kept frame is byte-swapped
// if the byte swap register is set, averaged (stereo) or halved (mono with byte
// swap), then divided by gain_divisor (0 acts as 1), truncating toward zero.
// Steps: a dropped frame does not stall the input; a kept frame is accepted,
// passes the 16 steps of the serial restoring divider and is then loaded into
// the output register, waiting while the previous result is still stalled there.
// in_stall is high from the accept of a kept frame until its result is loaded
// into the output register. Config writes must only be issued while the block
// is idle.

module pcm_decimate_downmix_gain (
    input  logic                             clk,
    input  logic                             rst_n,
    // config write port
    input  logic                             cfg_write,
    input  logic [pdg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pdg_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input frames
    input  logic                             in_valid,
    output logic                             in_stall,
    input  pdg_pkg::in_item_t                in_data,
    // output samples
    output logic                             out_valid,
    input  logic                             out_stall,
    output pdg_pkg::out_item_t               out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    // ---------------- configuration registers ----------------
    logic [pdg_pkg::RATE_W-1:0] source_rate_reg;
    logic [pdg_pkg::RATE_W-1:0] target_rate_reg;
    logic                       stereo_reg;
    logic                       byte_swap_reg;
    logic [pdg_pkg::GAIN_W-1:0] gain_divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_rate_reg   <= pdg_pkg::SOURCE_RATE_RST;
            target_rate_reg   <= pdg_pkg::TARGET_RATE_RST;
            stereo_reg        <= pdg_pkg::STEREO_RST;
            byte_swap_reg     <= pdg_pkg::BYTE_SWAP_RST;
            gain_divisor_reg  <= pdg_pkg::GAIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pdg_pkg::REG_SOURCE_RATE:   source_rate_reg   <= cfg_data;
                pdg_pkg::REG_TARGET_RATE:   target_rate_reg   <= cfg_data;
                pdg_pkg::REG_STEREO:        stereo_reg        <= cfg_data[0];
                pdg_pkg::REG_BYTE_SWAP:     byte_swap_reg     <= cfg_data[0];
                pdg_pkg::REG_GAIN_DIVISOR:
                    gain_divisor_reg <= cfg_data[pdg_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- phase accumulator ----------------
    logic [pdg_pkg::RATE_W-1:0] phase_reg;
    logic [pdg_pkg::RATE_W-1:0] phase_next;
    logic [pdg_pkg::RATE_W-1:0] step;
    logic [pdg_pkg::RATE_W:0]   sum;
    logic [pdg_pkg::RATE_W:0]   wrapped;
    logic                       keep;

    always_comb
    begin
        // effective target never exceeds the source rate
        step    = (target_rate_reg > source_rate_reg) ? source_rate_reg : target_rate_reg;
        sum     = {1'b0, phase_reg} + {1'b0, step};
        wrapped = sum - {1'b0, source_rate_reg};
        keep    = (sum >= {1'b0, source_rate_reg});
        phase_next = keep ? wrapped[pdg_pkg::RATE_W-1:0] : sum[pdg_pkg::RATE_W-1:0];
    end

    // ---------------- downmix front end ----------------
    logic [pdg_pkg::WORD_W-1:0] word_l;
    logic [pdg_pkg::WORD_W-1:0] word_r;
    logic signed [pdg_pkg::WORD_W:0] val_l;
    logic signed [pdg_pkg::WORD_W:0] val_r;
    logic signed [pdg_pkg::WORD_W:0] mix;
    logic signed [pdg_pkg::WORD_W:0] halved;
    logic signed [pdg_pkg::WORD_W:0] pre;
    logic signed [pdg_pkg::WORD_W:0] pre_abs;
    logic                            pre_neg;

    always_comb
    begin
        word_l = byte_swap_reg ? {in_data.first_word[7:0], in_data.first_word[15:8]}
                               : in_data.first_word;
        word_r = byte_swap_reg ? {in_data.second_word[7:0], in_data.second_word[15:8]}
                               : in_data.second_word;
        val_l  = $signed({word_l[pdg_pkg::WORD_W-1], word_l});
        val_r  = $signed({word_r[pdg_pkg::WORD_W-1], word_r});
        mix    = stereo_reg ? (val_l + val_r) : val_l;
        // halve toward zero: bias negatives by one before the shift
        halved = (mix + $signed({{pdg_pkg::WORD_W{1'b0}}, mix[pdg_pkg::WORD_W]})) >>> 1;
        pre    = (stereo_reg || byte_swap_reg) ? halved : val_l;
        pre_neg = pre[pdg_pkg::WORD_W];
        pre_abs = pre_neg ? -pre : pre;   // at most 32768
    end

    // ---------------- serial divider + sequencer ----------------
    localparam int unsigned CNT_W = $clog2(pdg_pkg::WORD_W);

    state_t                      state_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [pdg_pkg::WORD_W-1:0]  quo_reg;     // dividend shifts out, quotient in
    logic [pdg_pkg::GAIN_W-1:0]  rem_reg;
    logic                        neg_reg;
    logic                        blk_reg;
    logic                        out_valid_reg;
    pdg_pkg::out_item_t          out_data_reg;

    logic [pdg_pkg::GAIN_W-1:0]  gain;
    logic [pdg_pkg::WORD_W-1:0]  trial;
    logic [pdg_pkg::WORD_W-1:0]  trial_sub;
    logic                        fits;
    logic                        in_fire;
    logic                        out_free;

    always_comb
    begin
        gain      = (gain_divisor_reg == '0) ? pdg_pkg::GAIN_W'(1) : gain_divisor_reg;
        trial     = {rem_reg, quo_reg[pdg_pkg::WORD_W-1]};
        trial_sub = trial - {1'b0, gain};
        fits      = (trial >= {1'b0, gain});
        in_fire   = in_valid && !in_stall;
        out_free  = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
            blk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // a result loaded in ST_HOLD replaces the departing beat
            if (out_valid_reg && !out_stall && (state_reg != ST_HOLD))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        phase_reg <= phase_next;
                        if (keep)
                        begin
                            quo_reg   <= pre_abs[pdg_pkg::WORD_W-1:0];
                            rem_reg   <= '0;
                            neg_reg   <= pre_neg;
                            blk_reg   <= in_data.block_end;
                            cnt_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    // one restoring step per cycle
                    rem_reg <= fits ? trial_sub[pdg_pkg::GAIN_W-1:0]
                                    : trial[pdg_pkg::GAIN_W-1:0];
                    quo_reg <= {quo_reg[pdg_pkg::WORD_W-2:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(pdg_pkg::WORD_W - 1))
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        out_data_reg.sample        <= neg_reg ? -$signed(quo_reg)
                                                              : $signed(quo_reg);
                        out_data_reg.block_end_res <= blk_reg;
                        out_valid_reg              <= 1'b1;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
